[src/stb_pkg.sv]
package stb_pkg;

   localparam int TIMER_COUNT = 8;
   localparam int COUNT_WIDTH = 32;
   localparam int OPCODE_WIDTH = 2;
   localparam int ID_WIDTH = 8;
   localparam int START_WIDTH = 32;
   localparam int STATUS_WIDTH = 3;
   localparam int INDEX_WIDTH = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_START_ONESHOT  = 2'd0,
      OP_START_PERIODIC = 2'd1,
      OP_TICK           = 2'd2,
      OP_CHECK          = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK          = 3'd0,
      STATUS_BAD_ID      = 3'd1,
      STATUS_IN_USE      = 3'd2,
      STATUS_NOT_IN_USE  = 3'd3,
      STATUS_EXPIRED     = 3'd4,
      STATUS_NOT_EXPIRED = 3'd5
   } status_type;

   typedef struct packed {
      logic exec;
   } dp_cmd_type;

endpackage

[src/multi_channel_soft_timer_bank.sv]
// Latency: a result is valid the cycle after its request transfer.
// Throughput: one request per cycle; the single output register holds a
// result while rsp_stall is high and stalls the request side only then.
// Reset (synchronous, active high) frees every timer, clears all expired
// flags and mode bits, and empties the output register.
module multi_channel_soft_timer_bank
   import stb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [OPCODE_WIDTH-1:0] req_opcode,
   input  logic [ID_WIDTH-1:0]     req_timer_id,
   input  logic [START_WIDTH-1:0]  req_start_time,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STATUS_WIDTH-1:0] rsp_status
);

   dp_cmd_type cmd;

   stb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   stb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_opcode     (req_opcode),
      .req_timer_id   (req_timer_id),
      .req_start_time (req_start_time),
      .rsp_status     (rsp_status)
   );

endmodule

[src/stb_ctrl.sv]
module stb_ctrl
   import stb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   typedef enum logic {
      S_EMPTY,
      S_FULL
   } state_type;

   state_type state_ff;
   logic      accept;

   assign req_stall = (state_ff == S_FULL) && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign cmd.exec  = accept;
   assign rsp_valid = (state_ff == S_FULL);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_EMPTY;
      end else begin
         unique case (state_ff)
            S_EMPTY: begin
               if (accept) begin
                  state_ff <= S_FULL;
               end
            end
            S_FULL: begin
               if (!accept && !rsp_stall) begin
                  state_ff <= S_EMPTY;
               end
            end
            default: state_ff <= S_EMPTY;
         endcase
      end
   end

endmodule

[src/stb_datapath.sv]
module stb_datapath
   import stb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   input  logic [OPCODE_WIDTH-1:0] req_opcode,
   input  logic [ID_WIDTH-1:0]     req_timer_id,
   input  logic [START_WIDTH-1:0]  req_start_time,
   output logic [STATUS_WIDTH-1:0] rsp_status
);

   logic [COUNT_WIDTH-1:0] count_ff  [TIMER_COUNT];
   logic [COUNT_WIDTH-1:0] count_in  [TIMER_COUNT];
   logic [COUNT_WIDTH-1:0] reload_ff [TIMER_COUNT];
   logic [COUNT_WIDTH-1:0] reload_in [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] in_use_ff, in_use_in;
   logic [TIMER_COUNT-1:0] expired_ff, expired_in;
   logic [TIMER_COUNT-1:0] periodic_ff, periodic_in;
   status_type             status_ff, status_in;

   opcode_type             op;
   logic                   id_ok;
   logic [INDEX_WIDTH-1:0] idx;
   logic [COUNT_WIDTH-1:0] load_value;
   logic [COUNT_WIDTH-1:0] dec_value [TIMER_COUNT];

   assign op         = opcode_type'(req_opcode);
   assign id_ok      = ({1'b0, req_timer_id} < (ID_WIDTH + 1)'(TIMER_COUNT));
   assign idx        = req_timer_id[INDEX_WIDTH-1:0];
   assign load_value = req_start_time[COUNT_WIDTH-1:0];
   assign rsp_status = status_ff;

   always_comb begin
      for (int k = 0; k < TIMER_COUNT; k++) begin
         dec_value[k] = count_ff[k] - COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      count_in    = count_ff;
      reload_in   = reload_ff;
      in_use_in   = in_use_ff;
      expired_in  = expired_ff;
      periodic_in = periodic_ff;
      status_in   = STATUS_OK;
      unique case (op)
         OP_START_ONESHOT, OP_START_PERIODIC: begin
            if (!id_ok) begin
               status_in = STATUS_BAD_ID;
            end else if (in_use_ff[idx]) begin
               status_in = STATUS_IN_USE;
            end else begin
               in_use_in[idx]   = 1'b1;
               periodic_in[idx] = (op == OP_START_PERIODIC);
               count_in[idx]    = load_value;
               if (op == OP_START_PERIODIC) begin
                  reload_in[idx] = load_value;
               end
            end
         end
         OP_TICK: begin
            for (int k = 0; k < TIMER_COUNT; k++) begin
               if (in_use_ff[k] && (count_ff[k] != '0)) begin
                  if (dec_value[k] == '0) begin
                     expired_in[k] = 1'b1;
                     count_in[k]   = periodic_ff[k] ? reload_ff[k] : dec_value[k];
                  end else begin
                     count_in[k] = dec_value[k];
                  end
               end
            end
         end
         OP_CHECK: begin
            if (!id_ok) begin
               status_in = STATUS_BAD_ID;
            end else if (!in_use_ff[idx]) begin
               status_in = STATUS_NOT_IN_USE;
            end else if (!expired_ff[idx]) begin
               status_in = STATUS_NOT_EXPIRED;
            end else begin
               status_in       = STATUS_EXPIRED;
               expired_in[idx] = 1'b0;
               if (!periodic_ff[idx]) begin
                  in_use_in[idx] = 1'b0;
               end
            end
         end
         default: status_in = STATUS_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff   <= '0;
         expired_ff  <= '0;
         periodic_ff <= '0;
      end else if (cmd.exec) begin
         in_use_ff   <= in_use_in;
         expired_ff  <= expired_in;
         periodic_ff <= periodic_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         count_ff  <= count_in;
         reload_ff <= reload_in;
         status_ff <= status_in;
      end
   end

endmodule

[src/stb_checker.sv]
module stb_checker
   import stb_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [OPCODE_WIDTH-1:0] req_opcode,
   input logic [ID_WIDTH-1:0]     req_timer_id,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [STATUS_WIDTH-1:0] rsp_status
);

   logic req_xfer;

   assign req_xfer = req_valid && !req_stall;

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid)
      else $error("request transfer without a result");

   a_tick_ok: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_opcode == OP_TICK) |=> rsp_status == STATUS_OK)
      else $error("tick did not return ok");

   a_bad_id: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_opcode != OP_TICK)
      && ({1'b0, req_timer_id} >= (ID_WIDTH + 1)'(TIMER_COUNT))
      |=> rsp_status == STATUS_BAD_ID)
      else $error("out-of-range id not rejected");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STATUS_NOT_EXPIRED)
      else $error("status code out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");

endmodule

bind multi_channel_soft_timer_bank stb_checker u_stb_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_opcode   (req_opcode),
   .req_timer_id (req_timer_id),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status)
);

[dv/timer_bank_checker.sv]
module timer_bank_checker
   import stb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [OPCODE_WIDTH-1:0] req_opcode,
   input  logic [ID_WIDTH-1:0]     req_timer_id,
   input  logic [START_WIDTH-1:0]  req_start_time,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [STATUS_WIDTH-1:0] rsp_status,
   output int                      fail_count,
   output int                      pending_count
);

   logic [COUNT_WIDTH-1:0] count_left [TIMER_COUNT];
   logic [COUNT_WIDTH-1:0] reload_count [TIMER_COUNT];
   logic                   claimed [TIMER_COUNT];
   logic                   fired [TIMER_COUNT];
   logic                   repeating [TIMER_COUNT];
   status_type             due_status [$];

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic status_type apply_request(input opcode_type op,
                                                input logic [ID_WIDTH-1:0] id,
                                                input logic [START_WIDTH-1:0] start);
      logic [COUNT_WIDTH-1:0] load;
      logic [COUNT_WIDTH-1:0] next_count;
      load = start[COUNT_WIDTH-1:0];
      case (op)
         OP_START_ONESHOT, OP_START_PERIODIC: begin
            if (id >= TIMER_COUNT) return STATUS_BAD_ID;
            if (claimed[id]) return STATUS_IN_USE;
            claimed[id] = 1'b1;
            repeating[id] = (op == OP_START_PERIODIC);
            count_left[id] = load;
            if (op == OP_START_PERIODIC) reload_count[id] = load;
            return STATUS_OK;
         end
         OP_TICK: begin
            for (int k = 0; k < TIMER_COUNT; k++) begin
               if (claimed[k] && count_left[k] != '0) begin
                  next_count = count_left[k] - 1'b1;
                  if (next_count == '0) begin
                     fired[k] = 1'b1;
                     if (repeating[k]) next_count = reload_count[k];
                  end
                  count_left[k] = next_count;
               end
            end
            return STATUS_OK;
         end
         default: begin
            if (id >= TIMER_COUNT) return STATUS_BAD_ID;
            if (!claimed[id]) return STATUS_NOT_IN_USE;
            if (!fired[id]) return STATUS_NOT_EXPIRED;
            fired[id] = 1'b0;
            if (!repeating[id]) claimed[id] = 1'b0;
            return STATUS_EXPIRED;
         end
      endcase
   endfunction

   always @(posedge clock) begin : track
      status_type oldest;
      if (reset) begin
         for (int k = 0; k < TIMER_COUNT; k++) begin
            count_left[k] = '0;
            reload_count[k] = '0;
            claimed[k] = 1'b0;
            fired[k] = 1'b0;
            repeating[k] = 1'b0;
         end
         due_status.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_status.size() == 0) begin
               report_mismatch($sformatf("status %0d with no request pending", rsp_status));
            end else begin
               oldest = due_status.pop_front();
               if (rsp_status !== oldest)
                  report_mismatch($sformatf("status %0d, expected %0d", rsp_status, oldest));
            end
         end
         if (req_valid && !req_stall)
            due_status.push_back(apply_request(opcode_type'(req_opcode), req_timer_id,
                                               req_start_time));
      end
      pending_count <= due_status.size();
   end

endmodule

[dv/testbench.sv]
module testbench;
   import stb_pkg::*;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic [OPCODE_WIDTH-1:0] req_opcode;
   logic [ID_WIDTH-1:0]     req_timer_id;
   logic [START_WIDTH-1:0]  req_start_time;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [STATUS_WIDTH-1:0] rsp_status;
   int                      fail_count;
   int                      pending_count;

   int gap_max;
   int stall_max;
   bit hold_off;

   multi_channel_soft_timer_bank dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_timer_id(req_timer_id),
      .req_start_time(req_start_time),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status)
   );

   timer_bank_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_timer_id(req_timer_id),
      .req_start_time(req_start_time),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .fail_count(fail_count),
      .pending_count(pending_count)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #5000000;
      $display("testbench failed");
      $finish;
   end

   task automatic send_request(input opcode_type op, input logic [ID_WIDTH-1:0] id,
                               input logic [START_WIDTH-1:0] start);
      int gap;
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_timer_id <= id;
      req_start_time <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random;
      int roll;
      opcode_type op;
      logic [ID_WIDTH-1:0] id;
      logic [START_WIDTH-1:0] start;
      roll = $urandom_range(99, 0);
      if ($urandom_range(9, 0) == 0) id = ID_WIDTH'($urandom_range(255, TIMER_COUNT));
      else id = ID_WIDTH'($urandom_range(TIMER_COUNT - 1, 0));
      start = $urandom;
      if (roll < 30) begin
         op = OP_TICK;
      end else if (roll < 65) begin
         op = OP_CHECK;
      end else if (roll < 95) begin
         op = OP_START_ONESHOT;
         if (id < TIMER_COUNT) start = $urandom_range(8, 1);
      end else if (roll < 98) begin
         // keep periodic timers to two slots so the rest stay free for one-shots
         op = OP_START_PERIODIC;
         if (id < TIMER_COUNT) begin
            id = ($urandom_range(1, 0) != 0) ? ID_WIDTH'(1) : ID_WIDTH'(6);
            start = $urandom_range(5, 1);
         end
      end else begin
         op = OP_START_ONESHOT;
         if (id < TIMER_COUNT) begin
            id = ID_WIDTH'(7);
            start = '0;
         end
      end
      send_request(op, id, start);
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      @(posedge clock);
   endtask

   initial begin : drain
      int wait_cycles;
      bit hold_done;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         if (hold_off && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (60) @(posedge clock);
            hold_done = 1'b1;
         end
         wait_cycles = $urandom_range(stall_max, 0);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_TICK;
      req_timer_id = '0;
      req_start_time = '0;
      gap_max = 10;
      stall_max = 10;
      hold_off = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_START_ONESHOT, 0, 1);
      send_request(OP_START_PERIODIC, 1, 2);
      send_request(OP_START_ONESHOT, 7, 0);
      send_request(OP_START_PERIODIC, 8, 32'hFFFF_FFFF);
      send_request(OP_START_ONESHOT, 255, 32'hFFFF_FFFF);
      send_request(OP_START_PERIODIC, 0, 32'hFFFF_FFFF);
      send_request(OP_CHECK, 2, 0);
      send_request(OP_CHECK, 0, 32'hFFFF_FFFF);
      send_request(OP_CHECK, 255, 0);
      send_request(OP_TICK, 255, 32'hFFFF_FFFF);
      send_request(OP_CHECK, 0, 0);
      send_request(OP_CHECK, 0, 0);
      send_request(OP_CHECK, 1, 0);
      send_request(OP_TICK, 0, 0);
      send_request(OP_CHECK, 1, 0);
      send_request(OP_CHECK, 1, 0);
      send_request(OP_TICK, 0, 0);
      send_request(OP_TICK, 0, 0);
      send_request(OP_CHECK, 1, 0);
      send_request(OP_CHECK, 7, 0);
      send_request(OP_START_ONESHOT, 5, 32'hFFFF_FFFF);
      send_request(OP_TICK, 0, 0);
      send_request(OP_CHECK, 5, 0);
      send_request(OP_CHECK, 7, 0);

      repeat (200) send_random();

      // back-to-back with no idling on either side
      gap_max = 0;
      stall_max = 0;
      repeat (100) send_random();

      // hold the result side off long enough to back up the request side
      hold_off = 1'b1;
      repeat (40) send_random();
      wait_drained();

      gap_max = 10;
      stall_max = 10;
      repeat (120) send_random();
      wait_drained();

      gap_max = 2;
      stall_max = 10;
      repeat (60) send_random();
      gap_max = 10;
      stall_max = 1;
      repeat (60) send_random();

      wait_drained();
      repeat (5) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
